>>> src/pws_pkg.sv
package pws_pkg;

  localparam int CoordW = 32;
  localparam int ProdW = 64;
  localparam int ClipW = 58;
  localparam int DivW = 57;
  localparam int MagW = 58;
  localparam int MagHalf = 29;
  localparam int ScaleW = 21;
  localparam int NumW = 79;
  localparam int QuotW = 41;
  localparam int DivSteps = 41;
  localparam int DimW = 14;
  localparam int CfgIdxW = 8;
  localparam logic signed [ClipW-1:0] VisibleMinW = ClipW'(656);
  localparam logic [QuotW-1:0] QuotLimit = QuotW'(1) << (QuotW - 1);

  typedef enum logic [CfgIdxW-1:0] {
    REG_X_LO = 8'd0,
    REG_X_HI = 8'd1,
    REG_Y_LO = 8'd2,
    REG_Y_HI = 8'd3,
    REG_W_LO = 8'd4,
    REG_W_HI = 8'd5,
    REG_WIDTH = 8'd6,
    REG_HEIGHT = 8'd7
  } cfg_reg_t;

endpackage

>>> src/perspective_world_to_screen.sv
// Projects one world point per clock cycle to screen pixels. A transaction
// is accepted whenever start is high; busy is always low because the
// pipeline never stalls. Each result appears with done once it has passed
// through the pipeline: five stages form the dot products and the scaled
// numerators, 41 stages each resolve one quotient bit of the two dividers,
// and one stage saturates and registers the outputs. The receiver must take
// every result in the cycle that done is high.
module perspective_world_to_screen (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic signed [31:0]  pos_z,
  output logic                done,
  output logic signed [31:0]  screen_px,
  output logic signed [31:0]  screen_py,
  output logic signed [31:0]  clip_depth,
  output logic                in_front,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_index,
  input  logic [63:0]         cfg_data
);

  localparam int S = pws_pkg::DivSteps;

  logic [63:0] mat [0:5];
  logic [pws_pkg::DimW-1:0] screen_width;
  logic [pws_pkg::DimW-1:0] screen_height;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) mat[i] <= '0;
      screen_width <= pws_pkg::DimW'(1920);
      screen_height <= pws_pkg::DimW'(1080);
    end else if (cfg_valid) begin
      case (cfg_index)
        pws_pkg::REG_X_LO: mat[0] <= cfg_data;
        pws_pkg::REG_X_HI: mat[1] <= cfg_data;
        pws_pkg::REG_Y_LO: mat[2] <= cfg_data;
        pws_pkg::REG_Y_HI: mat[3] <= cfg_data;
        pws_pkg::REG_W_LO: mat[4] <= cfg_data;
        pws_pkg::REG_W_HI: mat[5] <= cfg_data;
        pws_pkg::REG_WIDTH: screen_width <= cfg_data[pws_pkg::DimW-1:0];
        pws_pkg::REG_HEIGHT: screen_height <= cfg_data[pws_pkg::DimW-1:0];
        default: ;
      endcase
    end
  end

  logic [pws_pkg::ScaleW-1:0] kw, kh;
  assign kw = {screen_width, 7'b0};
  assign kh = {screen_height, 7'b0};

  // Stage 1: the nine coefficient products.
  logic v1;
  logic signed [pws_pkg::ProdW-1:0] prod [0:8];
  logic signed [31:0] c3 [0:2];

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      prod[3*r]   <= $signed(mat[2*r][31:0]) * pos_x;
      prod[3*r+1] <= $signed(mat[2*r][63:32]) * pos_y;
      prod[3*r+2] <= $signed(mat[2*r+1][31:0]) * pos_z;
      c3[r] <= $signed(mat[2*r+1][63:32]);
    end
  end

  // Stage 2: floored terms summed into clip x, y and w.
  logic v2;
  logic signed [pws_pkg::ClipW-1:0] clip [0:2];

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      clip[r] <= pws_pkg::ClipW'(prod[3*r] >>> 8) + pws_pkg::ClipW'(prod[3*r+1] >>> 8)
               + pws_pkg::ClipW'(prod[3*r+2] >>> 8) + {{(pws_pkg::ClipW-32){c3[r][31]}}, c3[r]};
    end
  end

  // Stage 3: visibility, magnitudes and signs.
  logic v3, vis3, negx3, negy3;
  logic [pws_pkg::MagW-1:0] magx3, magy3;
  logic [pws_pkg::DivW-1:0] d3;

  always_ff @(posedge clk) begin
    vis3 <= clip[2] >= pws_pkg::VisibleMinW;
    negx3 <= clip[0][pws_pkg::ClipW-1];
    negy3 <= clip[1][pws_pkg::ClipW-1];
    magx3 <= clip[0][pws_pkg::ClipW-1] ? pws_pkg::MagW'(-clip[0]) : pws_pkg::MagW'(clip[0]);
    magy3 <= clip[1][pws_pkg::ClipW-1] ? pws_pkg::MagW'(-clip[1]) : pws_pkg::MagW'(clip[1]);
    d3 <= clip[2][pws_pkg::DivW-1:0];
  end

  // Stage 4: partial products of magnitude times pixel scale.
  localparam int PW = pws_pkg::MagHalf + pws_pkg::ScaleW;
  logic v4, vis4, negx4, negy4;
  logic [PW-1:0] plx4, phx4, ply4, phy4;
  logic [pws_pkg::DivW-1:0] d4;

  always_ff @(posedge clk) begin
    vis4 <= vis3;
    negx4 <= negx3;
    negy4 <= negy3;
    d4 <= d3;
    plx4 <= magx3[pws_pkg::MagHalf-1:0] * kw;
    phx4 <= magx3[pws_pkg::MagW-1:pws_pkg::MagHalf] * kw;
    ply4 <= magy3[pws_pkg::MagHalf-1:0] * kh;
    phy4 <= magy3[pws_pkg::MagW-1:pws_pkg::MagHalf] * kh;
  end

  logic [pws_pkg::NumW-1:0] nx4, ny4;
  logic ovfx4, ovfy4;
  assign nx4 = pws_pkg::NumW'(plx4) + (pws_pkg::NumW'(phx4) << pws_pkg::MagHalf);
  assign ny4 = pws_pkg::NumW'(ply4) + (pws_pkg::NumW'(phy4) << pws_pkg::MagHalf);
  assign ovfx4 = pws_pkg::DivW'(nx4[pws_pkg::NumW-1:pws_pkg::QuotW]) >= d4;
  assign ovfy4 = pws_pkg::DivW'(ny4[pws_pkg::NumW-1:pws_pkg::QuotW]) >= d4;

  // Divider stages; index 0 is loaded from stage 4.
  logic v [0:S];
  logic vis [0:S];
  logic negx [0:S];
  logic negy [0:S];
  logic ovfx [0:S];
  logic ovfy [0:S];
  logic [pws_pkg::DivW-1:0] d [0:S];
  logic [pws_pkg::DivW-1:0] rx [0:S];
  logic [pws_pkg::DivW-1:0] ry [0:S];
  logic [pws_pkg::QuotW-1:0] nlx [0:S];
  logic [pws_pkg::QuotW-1:0] nly [0:S];
  logic [pws_pkg::QuotW-1:0] qx [0:S];
  logic [pws_pkg::QuotW-1:0] qy [0:S];

  always_ff @(posedge clk) begin
    vis[0] <= vis4;
    negx[0] <= negx4;
    negy[0] <= negy4;
    ovfx[0] <= ovfx4;
    ovfy[0] <= ovfy4;
    d[0] <= d4;
    rx[0] <= ovfx4 ? '0 : pws_pkg::DivW'(nx4[pws_pkg::NumW-1:pws_pkg::QuotW]);
    ry[0] <= ovfy4 ? '0 : pws_pkg::DivW'(ny4[pws_pkg::NumW-1:pws_pkg::QuotW]);
    nlx[0] <= nx4[pws_pkg::QuotW-1:0];
    nly[0] <= ny4[pws_pkg::QuotW-1:0];
    qx[0] <= '0;
    qy[0] <= '0;
  end

  for (genvar k = 0; k < S; k++) begin : g_div
    logic [pws_pkg::DivW:0] tx, ty;
    logic gex, gey;
    assign tx = {rx[k], nlx[k][pws_pkg::QuotW-1]};
    assign ty = {ry[k], nly[k][pws_pkg::QuotW-1]};
    assign gex = tx >= {1'b0, d[k]};
    assign gey = ty >= {1'b0, d[k]};

    always_ff @(posedge clk) begin
      vis[k+1] <= vis[k];
      negx[k+1] <= negx[k];
      negy[k+1] <= negy[k];
      ovfx[k+1] <= ovfx[k];
      ovfy[k+1] <= ovfy[k];
      d[k+1] <= d[k];
      rx[k+1] <= gex ? pws_pkg::DivW'(tx - {1'b0, d[k]}) : pws_pkg::DivW'(tx);
      ry[k+1] <= gey ? pws_pkg::DivW'(ty - {1'b0, d[k]}) : pws_pkg::DivW'(ty);
      nlx[k+1] <= nlx[k] << 1;
      nly[k+1] <= nly[k] << 1;
      qx[k+1] <= {qx[k][pws_pkg::QuotW-2:0], gex};
      qy[k+1] <= {qy[k][pws_pkg::QuotW-2:0], gey};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      for (int i = 0; i <= S; i++) v[i] <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v[0] <= v4;
      for (int i = 0; i < S; i++) v[i+1] <= v[i];
    end
  end

  function automatic logic signed [31:0] sat32(input logic signed [pws_pkg::ClipW-1:0] a);
    if (a > pws_pkg::ClipW'(32'sh7fffffff)) return 32'sh7fffffff;
    if (a < -pws_pkg::ClipW'(33'sh080000000)) return 32'sh80000000;
    return a[31:0];
  endfunction

  // Output stage: clamp the quotients, offset, saturate.
  logic [pws_pkg::QuotW-1:0] qxc, qyc;
  logic signed [pws_pkg::ClipW-1:0] tq, uq, sx, sy;

  always_comb begin
    qxc = (ovfx[S] || qx[S] > pws_pkg::QuotLimit) ? pws_pkg::QuotLimit : qx[S];
    qyc = (ovfy[S] || qy[S] > pws_pkg::QuotLimit) ? pws_pkg::QuotLimit : qy[S];
    tq = negx[S] ? -pws_pkg::ClipW'(qxc) : pws_pkg::ClipW'(qxc);
    uq = negy[S] ? -pws_pkg::ClipW'(qyc) : pws_pkg::ClipW'(qyc);
    sx = pws_pkg::ClipW'(kw) + tq + pws_pkg::ClipW'(128);
    sy = pws_pkg::ClipW'(kh) - (uq + pws_pkg::ClipW'(128));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v[S];
    end
    in_front <= vis[S];
    screen_px <= vis[S] ? sat32(sx) : '0;
    screen_py <= vis[S] ? sat32(sy) : '0;
    clip_depth <= vis[S] ? sat32(pws_pkg::ClipW'(d[S])) : '0;
  end

endmodule
